@@ rtl/tvsg_pkg.sv @@
// Shared types, constants and tables of the three-voice sound generator.
// Used by tvsg_front, tvsg_engine and three_voice_sound_generator_top.
package tvsg_pkg;

    localparam int FRACTION_BITS    = 8;
    localparam int MASTER_GAIN_FULL = 255;
    localparam int VOICES           = 3;
    localparam int REG_COUNT        = 14;
    localparam int QUEUE_DEPTH      = 2;
    localparam int QPTR_W           = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W           = $clog2(QUEUE_DEPTH + 1);

    localparam int RATIO_W    = 24;
    localparam int TICK_SHIFT = FRACTION_BITS + 4;
    localparam int TOTAL_W    = RATIO_W + 1;
    localparam int TICK_W     = TOTAL_W - TICK_SHIFT;

    // Reciprocal for the division by full-scale gain.
    localparam int          GAIN_RECIP_SH = 31;
    localparam logic [31:0] GAIN_RECIP    =
        32'(((64'd1 << GAIN_RECIP_SH) + MASTER_GAIN_FULL - 1) / MASTER_GAIN_FULL);

    localparam logic signed [47:0] DC_POLE_Q15 = 48'sd32604;
    localparam logic signed [47:0] DC_ROUND    = 48'sd16384;

    typedef logic [1:0] t_op;
    localparam t_op OP_WRITE   = 2'd0;
    localparam t_op OP_READ    = 2'd1;
    localparam t_op OP_SAMPLE  = 2'd2;
    localparam t_op OP_IGNORED = 2'd3;

    typedef logic [1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_RATIO = 2'd0;
    localparam t_cfg_idx CFG_GAIN  = 2'd1;
    localparam t_cfg_idx CFG_PAN   = 2'd2;

    localparam logic [1:0] PAN_MONO = 2'd0;
    localparam logic [1:0] PAN_AB   = 2'd1;
    localparam logic [1:0] PAN_AC   = 2'd2;

    typedef logic [1:0] t_env_act;
    localparam t_env_act ENV_DECAY  = 2'd0;
    localparam t_env_act ENV_ATTACK = 2'd1;
    localparam t_env_act ENV_HOLD   = 2'd2;
    localparam t_env_act ENV_OFF    = 2'd3;

    localparam logic [3:0] REG_MIXER     = 4'd7;
    localparam logic [3:0] REG_ENV_SHAPE = 4'd13;

    typedef struct packed {
        t_op        op;
        logic [3:0] addr;
        logic [7:0] value;
    } t_cmd;

    typedef struct packed {
        logic [RATIO_W-1:0] ratio;
        logic [7:0]         gain;
        logic [1:0]         pan;
    } t_cfg;

    typedef struct packed {
        logic [15:0] cnt;
        logic        half;
        logic [3:0]  level;
    } t_env;

    function automatic logic [7:0] reg_mask(input logic [3:0] addr);
        case (addr)
            4'd1, 4'd3, 4'd5, 4'd13: reg_mask = 8'h0F;
            4'd6, 4'd8, 4'd9, 4'd10: reg_mask = 8'h1F;
            4'd7:                    reg_mask = 8'h3F;
            4'd14, 4'd15:            reg_mask = 8'h00;
            default:                 reg_mask = 8'hFF;
        endcase
    endfunction

    // Half of the DAC table value.
    function automatic logic [14:0] dac_half(input logic [3:0] idx);
        case (idx)
            4'd0:    dac_half = 15'd0;
            4'd1:    dac_half = 15'd256;
            4'd2:    dac_half = 15'd414;
            4'd3:    dac_half = 15'd619;
            4'd4:    dac_half = 15'd961;
            4'd5:    dac_half = 15'd1619;
            4'd6:    dac_half = 15'd2463;
            4'd7:    dac_half = 15'd4555;
            4'd8:    dac_half = 15'd5172;
            4'd9:    dac_half = 15'd8938;
            4'd10:   dac_half = 15'd12341;
            4'd11:   dac_half = 15'd15221;
            4'd12:   dac_half = 15'd19422;
            4'd13:   dac_half = 15'd23635;
            4'd14:   dac_half = 15'd28201;
            default: dac_half = 15'd32767;
        endcase
    endfunction

    // Envelope level scaled to full amplitude, rounded down.
    function automatic logic [14:0] env_amp(input logic [3:0] lvl);
        case (lvl)
            4'd0:    env_amp = 15'd0;
            4'd1:    env_amp = 15'd2184;
            4'd2:    env_amp = 15'd4368;
            4'd3:    env_amp = 15'd6553;
            4'd4:    env_amp = 15'd8737;
            4'd5:    env_amp = 15'd10922;
            4'd6:    env_amp = 15'd13106;
            4'd7:    env_amp = 15'd15291;
            4'd8:    env_amp = 15'd17475;
            4'd9:    env_amp = 15'd19660;
            4'd10:   env_amp = 15'd21844;
            4'd11:   env_amp = 15'd24029;
            4'd12:   env_amp = 15'd26213;
            4'd13:   env_amp = 15'd28398;
            4'd14:   env_amp = 15'd30582;
            default: env_amp = 15'd32767;
        endcase
    endfunction

    function automatic t_env_act env_action(input logic [3:0] shape, input logic half);
        case (shape)
            4'd0, 4'd1, 4'd2, 4'd3: env_action = half ? ENV_OFF : ENV_DECAY;
            4'd4, 4'd5, 4'd6, 4'd7: env_action = half ? ENV_OFF : ENV_ATTACK;
            4'd8:                   env_action = ENV_DECAY;
            4'd9:                   env_action = half ? ENV_OFF : ENV_DECAY;
            4'd10:                  env_action = half ? ENV_ATTACK : ENV_DECAY;
            4'd11:                  env_action = half ? ENV_HOLD : ENV_DECAY;
            4'd12:                  env_action = ENV_ATTACK;
            4'd13:                  env_action = half ? ENV_HOLD : ENV_ATTACK;
            4'd14:                  env_action = half ? ENV_DECAY : ENV_ATTACK;
            default:                env_action = half ? ENV_OFF : ENV_ATTACK;
        endcase
    endfunction

endpackage

@@ rtl/three_voice_sound_generator_top.sv @@
// Three-voice sound generator, top level: stream ports, configuration registers.
// Instantiates tvsg_front and tvsg_engine; depends on tvsg_pkg.
// A read result is registered on acceptance. A sample steps (clock_ratio_q8 + remainder) >> 12
// ticks, one tick per cycle, then the mix, DC, gain, divide and output states.
// Throughput: one item at a time in the engine; a two-entry queue buffers input.
// Reset: synchronous, active low; clears all generator and filter state.
module three_voice_sound_generator_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // reg_addr[3:0], reg_value[11:4], zero pad
    input  logic [1:0]  s_axis_tuser,   // op[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // left_sample, right_sample, read_data
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [23:0] i_cfg_data
);

    tvsg_pkg::t_cfg r_cfg;
    tvsg_pkg::t_cmd w_in_cmd, w_cmd;
    logic w_cmd_valid, w_cmd_ready;
    logic [15:0] w_left, w_right;
    logic [7:0]  w_read_data;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ratio <= 24'd10294;
            r_cfg.gain  <= 8'd255;
            r_cfg.pan   <= tvsg_pkg::PAN_AB;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                tvsg_pkg::CFG_RATIO: r_cfg.ratio <= i_cfg_data;
                tvsg_pkg::CFG_GAIN:  r_cfg.gain  <= i_cfg_data[7:0];
                tvsg_pkg::CFG_PAN:   r_cfg.pan   <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    assign w_in_cmd.op    = s_axis_tuser;
    assign w_in_cmd.addr  = s_axis_tdata[3:0];
    assign w_in_cmd.value = s_axis_tdata[11:4];

    tvsg_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_cmd       (w_in_cmd),
        .o_cmd_valid (w_cmd_valid),
        .i_cmd_ready (w_cmd_ready),
        .o_cmd       (w_cmd)
    );

    tvsg_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd_valid (w_cmd_valid),
        .o_cmd_ready (w_cmd_ready),
        .i_cmd       (w_cmd),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_left      (w_left),
        .o_right     (w_right),
        .o_read_data (w_read_data)
    );

    assign m_axis_tdata = {w_read_data, w_right, w_left};

    // A full input queue always has a command waiting for the engine.
    a_full_has_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> w_cmd_valid)
        else $error("input stalled with empty queue");

    // A read taken by the engine is presented on the next cycle.
    a_read_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd_valid && w_cmd_ready && w_cmd.op == tvsg_pkg::OP_READ) |=> m_axis_tvalid)
        else $error("read result missing");

    // A register write never creates a result.
    a_write_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd_valid && w_cmd_ready && w_cmd.op == tvsg_pkg::OP_WRITE && !m_axis_tvalid)
        |=> !m_axis_tvalid)
        else $error("write produced a result");

endmodule

@@ rtl/tvsg_front.sv @@
// Front end: accepts input items, drops unused op codes and queues commands.
// Depends on tvsg_pkg for the command type and queue depth.
module tvsg_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  tvsg_pkg::t_cmd i_cmd,
    output logic          o_cmd_valid,
    input  logic          i_cmd_ready,
    output tvsg_pkg::t_cmd o_cmd
);

    tvsg_pkg::t_cmd r_queue [tvsg_pkg::QUEUE_DEPTH];
    logic [tvsg_pkg::QPTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [tvsg_pkg::QCNT_W-1:0] r_count;
    logic w_push, w_pop;

    assign o_ready     = (r_count < tvsg_pkg::QCNT_W'(tvsg_pkg::QUEUE_DEPTH));
    assign o_cmd_valid = (r_count != '0);
    assign o_cmd       = r_queue[r_rd_ptr];
    assign w_push      = i_valid && o_ready && (i_cmd.op != tvsg_pkg::OP_IGNORED);
    assign w_pop       = o_cmd_valid && i_cmd_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == tvsg_pkg::QPTR_W'(tvsg_pkg::QUEUE_DEPTH - 1)) ?
                            '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == tvsg_pkg::QPTR_W'(tvsg_pkg::QUEUE_DEPTH - 1)) ?
                            '0 : r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!w_push && w_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_queue[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

@@ rtl/tvsg_engine.sv @@
// Back end: chip registers, tone/noise/envelope generators, mixer, DC blocker, gain.
// Depends on tvsg_pkg; fed by tvsg_front through its command queue.
module tvsg_engine (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  tvsg_pkg::t_cfg i_cfg,
    input  logic           i_cmd_valid,
    output logic           o_cmd_ready,
    input  tvsg_pkg::t_cmd i_cmd,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output logic [15:0]    o_left,
    output logic [15:0]    o_right,
    output logic [7:0]     o_read_data
);

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_TICK = 7'b0000010,
        ST_MIX  = 7'b0000100,
        ST_DC   = 7'b0001000,
        ST_GAIN = 7'b0010000,
        ST_DIV  = 7'b0100000,
        ST_OUT  = 7'b1000000
    } t_state;

    t_state r_state, n_state;

    logic [7:0]  r_regs [tvsg_pkg::REG_COUNT];
    logic [11:0] r_tone_cnt [tvsg_pkg::VOICES];
    logic        r_tone_ph  [tvsg_pkg::VOICES];
    logic [4:0]  r_noise_cnt;
    logic [16:0] r_noise_sh;
    logic        r_noise_bit;
    tvsg_pkg::t_env r_env;
    logic [3:0]  r_env_shape;
    logic [tvsg_pkg::TICK_SHIFT-1:0] r_remain;
    logic [tvsg_pkg::TICK_W-1:0]     r_ticks;
    logic signed [31:0] r_xh_l, r_xh_r, r_yh_l, r_yh_r;

    logic [14:0] r_mix_l, r_mix_r;
    logic signed [16:0] r_v_l, r_v_r;
    logic signed [25:0] r_p_l, r_p_r;
    logic [25:0] r_q_l, r_q_r;
    logic        r_neg_l, r_neg_r;

    logic        r_out_valid;
    logic [15:0] r_out_left, r_out_right;
    logic [7:0]  r_out_data;

    logic w_out_free, w_take, w_out_load;
    logic [tvsg_pkg::TOTAL_W-1:0] w_total;

    // Generator next-state after one tick.
    logic [11:0] n_tone_cnt [tvsg_pkg::VOICES];
    logic        n_tone_ph  [tvsg_pkg::VOICES];
    logic [4:0]  n_noise_cnt;
    logic [16:0] n_noise_sh;
    logic        n_noise_bit;
    tvsg_pkg::t_env n_env;

    logic [14:0] w_voice [tvsg_pkg::VOICES];
    logic [14:0] w_mix_l, w_mix_r;
    logic [16:0] w_sum3;
    logic [32:0] w_mono_prod;
    logic signed [31:0] w_y_l, w_y_r;
    logic [7:0]  w_gain;

    function automatic logic [11:0] tone_period(input logic [7:0] lo, input logic [7:0] hi);
        logic [11:0] p;
        p = {hi[3:0], lo};
        tone_period = (p == '0) ? 12'd1 : p;
    endfunction

    function automatic tvsg_pkg::t_env env_half(input tvsg_pkg::t_env e,
                                                input logic [3:0] shape,
                                                input logic [15:0] period);
        tvsg_pkg::t_env r;
        tvsg_pkg::t_env_act act;
        r = e;
        r.cnt = e.cnt + 16'd1;
        act = tvsg_pkg::env_action(shape, e.half);
        if (r.cnt >= period) begin
            r.cnt = '0;
            case (act)
                tvsg_pkg::ENV_ATTACK: begin
                    r.level = e.level + 4'd1;
                    if (r.level == 4'd15) r.half = ~e.half;
                end
                tvsg_pkg::ENV_DECAY: begin
                    r.level = e.level - 4'd1;
                    if (r.level == 4'd0) r.half = ~e.half;
                end
                tvsg_pkg::ENV_OFF: r.level = '0;
                default: r.level = e.level;
            endcase
        end
        env_half = r;
    endfunction

    function automatic logic signed [31:0] dc_step(input logic signed [31:0] x,
                                                   input logic signed [31:0] xp,
                                                   input logic signed [31:0] yp);
        logic signed [47:0] fbp, y48;
        fbp = 48'(yp) * tvsg_pkg::DC_POLE_Q15 + tvsg_pkg::DC_ROUND;
        y48 = 48'(x) - 48'(xp) + (fbp >>> 15);
        dc_step = y48[31:0];
    endfunction

    assign w_out_free  = !r_out_valid || i_out_ready;
    assign o_cmd_ready = (r_state == ST_IDLE) &&
                         ((i_cmd.op != tvsg_pkg::OP_READ) || w_out_free);
    assign w_take      = i_cmd_valid && o_cmd_ready;
    assign w_out_load  = (w_take && i_cmd.op == tvsg_pkg::OP_READ) ||
                         (r_state == ST_OUT && w_out_free);
    assign w_total     = tvsg_pkg::TOTAL_W'(i_cfg.ratio) + tvsg_pkg::TOTAL_W'(r_remain);
    assign w_gain      = (i_cfg.gain > 8'(tvsg_pkg::MASTER_GAIN_FULL)) ?
                         8'(tvsg_pkg::MASTER_GAIN_FULL) : i_cfg.gain;

    // One generator tick: sync equal periods, then two half-clocks of everything.
    always_comb begin
        logic [11:0] per [tvsg_pkg::VOICES];
        logic [4:0]  nper;
        logic [15:0] eper;
        logic        fb;
        for (int c = 0; c < tvsg_pkg::VOICES; c++) begin
            per[c]        = tone_period(r_regs[2*c], r_regs[2*c+1]);
            n_tone_cnt[c] = r_tone_cnt[c];
            n_tone_ph[c]  = r_tone_ph[c];
        end
        if (per[0] == per[1] && n_tone_cnt[0] != n_tone_cnt[1]) begin
            n_tone_cnt[0] = n_tone_cnt[1];
            n_tone_ph[0]  = n_tone_ph[1];
        end
        if (per[0] == per[2] && n_tone_cnt[0] != n_tone_cnt[2]) begin
            n_tone_cnt[0] = n_tone_cnt[2];
            n_tone_ph[0]  = n_tone_ph[2];
        end
        if (per[1] == per[2] && n_tone_cnt[1] != n_tone_cnt[2]) begin
            n_tone_cnt[1] = n_tone_cnt[2];
            n_tone_ph[1]  = n_tone_ph[2];
        end
        for (int c = 0; c < tvsg_pkg::VOICES; c++) begin
            for (int h = 0; h < 2; h++) begin
                n_tone_cnt[c] = n_tone_cnt[c] + 12'd1;
                if (n_tone_cnt[c] >= per[c]) begin
                    n_tone_cnt[c] = '0;
                    n_tone_ph[c]  = ~n_tone_ph[c];
                end
            end
        end
        nper        = (r_regs[6][4:0] == '0) ? 5'd1 : r_regs[6][4:0];
        n_noise_cnt = r_noise_cnt;
        n_noise_sh  = r_noise_sh;
        n_noise_bit = r_noise_bit;
        fb          = 1'b0;
        for (int h = 0; h < 2; h++) begin
            n_noise_cnt = n_noise_cnt + 5'd1;
            if (n_noise_cnt >= nper) begin
                fb          = n_noise_sh[0] ^ n_noise_sh[3];
                n_noise_cnt = '0;
                n_noise_sh  = {fb, n_noise_sh[16:1]};
                n_noise_bit = n_noise_sh[0];
            end
        end
        eper  = {r_regs[12], r_regs[11]};
        eper  = (eper == '0) ? 16'd1 : eper;
        n_env = env_half(r_env, r_env_shape, eper);
        n_env = env_half(n_env, r_env_shape, eper);
    end

    // Voice gating and panning.
    always_comb begin
        logic [7:0]  mix;
        logic [7:0]  vol;
        logic [15:0] s_a, s_b;
        mix = r_regs[tvsg_pkg::REG_MIXER];
        for (int c = 0; c < tvsg_pkg::VOICES; c++) begin
            vol = r_regs[8+c];
            if ((mix[c] || r_tone_ph[c]) && (mix[3+c] || r_noise_bit)) begin
                w_voice[c] = vol[4] ? tvsg_pkg::env_amp(r_env.level) :
                                      tvsg_pkg::dac_half(vol[3:0]);
            end else begin
                w_voice[c] = '0;
            end
        end
        w_sum3      = 17'(w_voice[0]) + 17'(w_voice[1]) + 17'(w_voice[2]);
        // Divide by three: exact for sums below 2^17.
        w_mono_prod = 33'(w_sum3) * 33'd43691;
        s_b         = 16'(w_voice[1]) + 16'(w_voice[2]);
        s_a         = (i_cfg.pan == tvsg_pkg::PAN_AC) ?
                      16'(w_voice[0]) + 16'(w_voice[2]) :
                      16'(w_voice[0]) + 16'(w_voice[1]);
        if (i_cfg.pan == tvsg_pkg::PAN_MONO) begin
            w_mix_l = w_mono_prod[31:17];
            w_mix_r = w_mono_prod[31:17];
        end else begin
            w_mix_l = s_a[15:1];
            w_mix_r = s_b[15:1];
        end
    end

    assign w_y_l = dc_step({2'b00, r_mix_l, 15'd0}, r_xh_l, r_yh_l);
    assign w_y_r = dc_step({2'b00, r_mix_r, 15'd0}, r_xh_r, r_yh_r);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_take && i_cmd.op == tvsg_pkg::OP_SAMPLE) begin
                    n_state = (w_total[tvsg_pkg::TOTAL_W-1:tvsg_pkg::TICK_SHIFT] == '0) ?
                              ST_MIX : ST_TICK;
                end
            end
            ST_TICK: n_state = (r_ticks == tvsg_pkg::TICK_W'(1)) ? ST_MIX : ST_TICK;
            ST_MIX:  n_state = ST_DC;
            ST_DC:   n_state = ST_GAIN;
            ST_GAIN: n_state = ST_DIV;
            ST_DIV:  n_state = ST_OUT;
            ST_OUT:  n_state = w_out_free ? ST_IDLE : ST_OUT;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            for (int i = 0; i < tvsg_pkg::REG_COUNT; i++) r_regs[i] <= '0;
            for (int c = 0; c < tvsg_pkg::VOICES; c++) begin
                r_tone_cnt[c] <= '0;
                r_tone_ph[c]  <= 1'b1;
            end
            r_noise_cnt <= '0;
            r_noise_sh  <= 17'd1;
            r_noise_bit <= 1'b1;
            r_env       <= '0;
            r_env_shape <= '0;
            r_remain    <= '0;
            r_xh_l      <= '0;
            r_xh_r      <= '0;
            r_yh_l      <= '0;
            r_yh_r      <= '0;
        end else begin
            r_state <= n_state;
            if (r_out_valid && i_out_ready && !w_out_load) begin
                r_out_valid <= 1'b0;
            end
            if (w_take) begin
                case (i_cmd.op)
                    tvsg_pkg::OP_WRITE: begin
                        if (i_cmd.addr < 4'(tvsg_pkg::REG_COUNT)) begin
                            r_regs[i_cmd.addr] <= i_cmd.value & tvsg_pkg::reg_mask(i_cmd.addr);
                        end
                        if (i_cmd.addr == tvsg_pkg::REG_ENV_SHAPE) begin
                            r_env.cnt   <= '0;
                            r_env.half  <= 1'b0;
                            r_env.level <= i_cmd.value[2] ? 4'd0 : 4'd15;
                            r_env_shape <= i_cmd.value[3:0];
                        end
                    end
                    tvsg_pkg::OP_READ: begin
                        r_out_valid <= 1'b1;
                        r_out_left  <= '0;
                        r_out_right <= '0;
                        r_out_data  <= (i_cmd.addr < 4'(tvsg_pkg::REG_COUNT)) ?
                                       r_regs[i_cmd.addr] : 8'd0;
                    end
                    tvsg_pkg::OP_SAMPLE: begin
                        r_remain <= w_total[tvsg_pkg::TICK_SHIFT-1:0];
                        r_ticks  <= w_total[tvsg_pkg::TOTAL_W-1:tvsg_pkg::TICK_SHIFT];
                    end
                    default: ;
                endcase
            end
            if (r_state == ST_TICK) begin
                r_tone_cnt  <= n_tone_cnt;
                r_tone_ph   <= n_tone_ph;
                r_noise_cnt <= n_noise_cnt;
                r_noise_sh  <= n_noise_sh;
                r_noise_bit <= n_noise_bit;
                r_env       <= n_env;
                r_ticks     <= r_ticks - 1'b1;
            end
            if (r_state == ST_DC) begin
                r_xh_l <= {2'b00, r_mix_l, 15'd0};
                r_xh_r <= {2'b00, r_mix_r, 15'd0};
                r_yh_l <= w_y_l;
                r_yh_r <= w_y_r;
            end
            if (r_state == ST_OUT && w_out_free) begin
                r_out_valid <= 1'b1;
                r_out_data  <= '0;
                r_out_left  <= r_neg_l ? ((r_q_l > 26'd32768) ? 16'h8000 : 16'(-r_q_l)) :
                                         ((r_q_l > 26'd32767) ? 16'h7FFF : r_q_l[15:0]);
                r_out_right <= r_neg_r ? ((r_q_r > 26'd32768) ? 16'h8000 : 16'(-r_q_r)) :
                                         ((r_q_r > 26'd32767) ? 16'h7FFF : r_q_r[15:0]);
            end
        end
    end

    // Arithmetic pipeline registers, one stage per state.
    always_ff @(posedge i_clk) begin
        logic [24:0] m_l, m_r;
        logic [56:0] pr_l, pr_r;
        m_l  = r_p_l[25] ? 25'(-r_p_l) : r_p_l[24:0];
        m_r  = r_p_r[25] ? 25'(-r_p_r) : r_p_r[24:0];
        pr_l = 57'(m_l) * 57'(tvsg_pkg::GAIN_RECIP);
        pr_r = 57'(m_r) * 57'(tvsg_pkg::GAIN_RECIP);
        if (r_state == ST_MIX) begin
            r_mix_l <= w_mix_l;
            r_mix_r <= w_mix_r;
        end
        if (r_state == ST_DC) begin
            r_v_l <= w_y_l[31:15];
            r_v_r <= w_y_r[31:15];
        end
        if (r_state == ST_GAIN) begin
            r_p_l <= 26'(r_v_l) * $signed({18'd0, w_gain});
            r_p_r <= 26'(r_v_r) * $signed({18'd0, w_gain});
        end
        if (r_state == ST_DIV) begin
            r_neg_l <= r_p_l[25];
            r_neg_r <= r_p_r[25];
            r_q_l   <= pr_l[56:tvsg_pkg::GAIN_RECIP_SH];
            r_q_r   <= pr_r[56:tvsg_pkg::GAIN_RECIP_SH];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_left      = r_out_left;
    assign o_right     = r_out_right;
    assign o_read_data = r_out_data;

endmodule
